// ===== hdl/mcmm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcmm_pkg
// Shared constants and types for the meet-in-the-middle clique search.
// ----------------------------------------------------------------------------
package mcmm_pkg;

  localparam int unsigned VIDX_W  = 5;
  localparam int unsigned ROW_W   = 32;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned SIZE_W  = 6;

  localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_LOW,
    ST_HIGH,
    ST_COMB_RD,
    ST_COMB_ACC,
    ST_DONE
  } mcmm_state_t;

endpackage : mcmm_pkg
`default_nettype wire

// ===== hdl/mcmm_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcmm_row_if / mcmm_res_if
// Valid/ready channels for adjacency rows and clique-size results.
// ----------------------------------------------------------------------------
interface mcmm_row_if;
  logic        valid;
  logic        ready;
  logic [4:0]  vertex_index;
  logic [31:0] neighbour_row;
  logic        last_row;
  modport source (output valid, vertex_index, neighbour_row, last_row, input ready);
  modport sink (input valid, vertex_index, neighbour_row, last_row, output ready);
endinterface : mcmm_row_if

interface mcmm_res_if;
  logic       valid;
  logic       ready;
  logic [5:0] clique_size;
  modport source (output valid, clique_size, input ready);
  modport sink (input valid, clique_size, output ready);
endinterface : mcmm_res_if
`default_nettype wire

// ===== hdl/mcmm_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcmm_table
// Best-size table for one half: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mcmm_table #(
  parameter int unsigned ADDR_W = 16,
  parameter int unsigned DATA_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : mcmm_table
`default_nettype wire

// ===== hdl/max_clique_meet_in_middle.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// max_clique_meet_in_middle
// Maximum clique size by meet in the middle over two best-size tables.
// ----------------------------------------------------------------------------
// Rows are taken one word per cycle while loading. The word flagged last_row starts
// a search during which rows_in is not ready: the low table (L = floor(n/2)
// vertices) is filled first and then the high table (H = n - L vertices), one
// candidate vertex per cycle through the single read port of each table plus a
// drain step per subset for the last read to land, then the low subsets are
// combined, each by a read state and an accumulate state. The result moves into
// the output register, where it is held until taken while new rows load; a search
// that ends while the previous result is still waiting holds there until taken.
module max_clique_meet_in_middle #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned HALF_BITS    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  mcmm_row_if.sink         rows_in,
  mcmm_res_if.source       result_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import mcmm_pkg::*;

  localparam int unsigned HB    = HALF_BITS;
  localparam int unsigned JW    = (HB > 1) ? $clog2(HB) : 1;
  localparam int unsigned CW    = $clog2(HB + 1);
  localparam int unsigned MAXN  = (MAX_VERTICES < 2 * HB) ? MAX_VERTICES : 2 * HB;
  localparam int unsigned RIDX  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  logic [COUNT_W-1:0] vertex_count;
  logic [ROW_W-1:0]   adj [MAX_VERTICES];
  mcmm_state_t        state, state_next;

  logic [CW-1:0]  low_w, high_w, width;
  logic [HB:0]    mask;
  logic [JW-1:0]  j;
  logic [SIZE_W-1:0] best;
  logic           clq;
  logic [SIZE_W-1:0] result;
  logic           out_valid;
  logic [SIZE_W-1:0] out_size;

  wire logic out_free = !out_valid || result_out.ready;

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == {REG_VERTEX_COUNT, 1'b0})
                  ? {{(32 - COUNT_W){1'b0}}, vertex_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= COUNT_W'(32);
    end else if (psel && penable && pwrite && paddr[1:0] == {REG_VERTEX_COUNT, 1'b0}) begin
      vertex_count <= pwdata[COUNT_W-1:0];
    end
  end

  // Effective vertex count and the split into halves.
  logic [COUNT_W-1:0] n_eff;
  always_comb begin
    n_eff = (32'(vertex_count) > MAXN) ? COUNT_W'(MAXN) : vertex_count;
    low_w  = CW'(n_eff >> 1);
    high_w = CW'(n_eff - (n_eff >> 1));
  end

  wire logic acc_row = rows_in.valid && rows_in.ready;
  assign rows_in.ready = (state == ST_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_VERTICES; i++) adj[i] <= '0;
    end else if (acc_row && 32'(rows_in.vertex_index) < MAX_VERTICES) begin
      adj[rows_in.vertex_index[RIDX-1:0]] <= rows_in.neighbour_row
                                            | (ROW_W'(1) << rows_in.vertex_index);
    end
  end

  // Half-local row of vertex base+j.
  logic [5:0]    base;
  logic [5:0]    vsel;
  logic [63:0]   row_ext;
  logic [HB-1:0] half_row, half_mask;
  assign base  = (state == ST_HIGH) ? 6'(low_w) : 6'd0;
  assign width = (state == ST_HIGH) ? high_w : low_w;
  assign vsel  = base + 6'(j);
  assign row_ext = (32'(vsel) < MAX_VERTICES) ? {32'd0, adj[vsel[RIDX-1:0]]} : 64'd0;
  assign half_mask = HB'((64'd1 << width) - 64'd1);
  assign half_row  = HB'(row_ext >> base) & half_mask;

  // Table fill: one candidate bit j per cycle; the sub-entry read for bit j
  // returns the cycle after and is folded then.
  logic [HB-1:0] m;
  assign m = mask[HB-1:0];
  wire logic jbit = m[j];
  wire logic jlast = (32'(j) + 1 >= 32'(width));

  logic              pend;
  logic [SIZE_W-1:0] lo_rd, hi_rd;
  logic [HB-1:0]     lo_raddr, hi_raddr;
  logic              lo_we, hi_we;
  logic [SIZE_W-1:0] fill_w;
  logic [CW-1:0]     popc;
  logic [SIZE_W-1:0] best_fold;

  always_comb begin
    popc = '0;
    for (int i = 0; i < HB; i++) popc = popc + CW'(m[i]);
  end

  wire logic [SIZE_W-1:0] rd_cur = (state == ST_HIGH) ? hi_rd : lo_rd;
  assign best_fold = (pend && rd_cur > best) ? rd_cur : best;
  wire logic clq_now = clq && !(jbit && ((m & ~half_row) != '0));
  assign fill_w = clq_now ? SIZE_W'(popc) : best_fold;

  // Cycle at which the last sub-read lands: the cycle after j runs out.
  logic drain;
  wire logic filling = (state == ST_LOW || state == ST_HIGH);
  wire logic fill_done = filling && drain;
  wire logic [HB:0] limit = (HB + 1)'(1) << width;

  // Combine: common neighbours computed over stored rows per low mask.
  logic [HB-1:0] common;
  always_comb begin
    logic [63:0] c;
    c = (64'd1 << n_eff) - 64'd1;
    for (int i = 0; i < HB; i++) begin
      if (32'(i) < 32'(low_w) && m[i] && i < MAX_VERTICES) c = c & {32'd0, adj[i]};
    end
    common = HB'(c >> low_w);
  end

  wire logic [SIZE_W-1:0] comb_sum = lo_rd + hi_rd;

  always_comb begin
    lo_raddr = m & ~(HB'(1) << j);
    hi_raddr = lo_raddr;
    if (state == ST_COMB_RD) begin
      lo_raddr = m;
      hi_raddr = common;
    end
    lo_we = (state == ST_LOW) && drain;
    hi_we = (state == ST_HIGH) && drain;
  end

  mcmm_table #(.ADDR_W(HB), .DATA_W(SIZE_W)) u_low (
    .clk, .we(lo_we), .waddr(m), .wdata(fill_w), .raddr(lo_raddr), .rdata(lo_rd));
  mcmm_table #(.ADDR_W(HB), .DATA_W(SIZE_W)) u_high (
    .clk, .we(hi_we), .waddr(m), .wdata(fill_w), .raddr(hi_raddr), .rdata(hi_rd));

  // Next state. A half of width zero still runs one pass so that entry 0 is
  // written.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:     if (acc_row && rows_in.last_row) state_next = ST_LOW;
      ST_LOW:      if (fill_done && mask + 1 >= limit) state_next = ST_HIGH;
      ST_HIGH:     if (fill_done && mask + 1 >= limit) state_next = ST_COMB_RD;
      ST_COMB_RD:  state_next = ST_COMB_ACC;
      ST_COMB_ACC: if (mask + 1 >= ((HB + 1)'(1) << low_w)) state_next = ST_DONE;
                   else state_next = ST_COMB_RD;
      ST_DONE:     if (out_free) state_next = ST_LOAD;
      default:     state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Datapath sequencing. Entry 0 is written on the first pass (mask 0 is a clique
  // of size 0), so every entry is written before any read of it.
  always_ff @(posedge clk) begin
    if (state != state_next && (state_next == ST_LOW || state_next == ST_HIGH
        || state_next == ST_COMB_RD && state != ST_COMB_ACC)) begin
      mask <= '0; j <= '0; best <= '0; clq <= 1'b1; pend <= 1'b0; drain <= 1'b0;
      if (state_next == ST_COMB_RD) result <= '0;
    end else if (filling) begin
      if (drain) begin
        mask <= mask + 1'b1; j <= '0; best <= '0; clq <= 1'b1; pend <= 1'b0;
        drain <= 1'b0;
      end else begin
        best  <= best_fold;
        clq   <= clq_now;
        pend  <= jbit;
        if (jlast || width == '0) drain <= 1'b1;
        else j <= j + 1'b1;
      end
    end else if (state == ST_COMB_ACC) begin
      if (comb_sum > result) result <= comb_sum;
      mask <= mask + 1'b1;
    end
  end

  // Output register: frees the row side while the result word waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
      out_size  <= result;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Outputs.
  always_comb begin
    result_out.valid       = out_valid;
    result_out.clique_size = out_size;
  end

endmodule : max_clique_meet_in_middle
`default_nettype wire

// ===== sim/mcmm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mcmm_checker
// Watches the row, result and register ports of the clique search. On each
// row word flagged last it predicts the clique size and compares it with the
// result words as they are taken.
// ----------------------------------------------------------------------------
module mcmm_checker
  import mcmm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  mcmm_row_if              rows,
  mcmm_res_if              res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               pending
);

  localparam int unsigned NUM_VERT = 32;
  localparam int unsigned HALF     = 16;

  logic [COUNT_W-1:0] vcount;
  logic [ROW_W-1:0]   adj [NUM_VERT];
  logic [5:0]         low_best  [1 << HALF];
  logic [5:0]         high_best [1 << HALF];
  logic [SIZE_W-1:0]  sizes_due [$];

  function automatic int unsigned ones(logic [31:0] v);
    int unsigned c;
    c = 0;
    for (int i = 0; i < 32; i++) c += v[i];
    return c;
  endfunction

  // Fills the best-size table of one half; sel picks the low or high table.
  task automatic fill_table(bit sel, int unsigned base, int unsigned width);
    logic [31:0] lim;
    logic [31:0] hmask;
    logic [31:0] nrow;
    logic [5:0]  top_size;
    logic [5:0]  sub;
    bit          is_clique;
    lim   = 32'd1 << width;
    hmask = lim - 1;
    if (sel) high_best[0] = '0;
    else low_best[0] = '0;
    for (logic [31:0] m = 1; m < lim; m++) begin
      top_size  = '0;
      is_clique = 1'b1;
      for (int unsigned j = 0; j < width; j++) begin
        if (m[j]) begin
          sub  = sel ? high_best[m & ~(32'd1 << j)] : low_best[m & ~(32'd1 << j)];
          nrow = (adj[base + j] >> base) & hmask;
          if (sub > top_size) top_size = sub;
          if ((m & ~nrow) != 0) is_clique = 1'b0;
        end
      end
      if (is_clique) top_size = 6'(ones(m));
      if (sel) high_best[m] = top_size;
      else low_best[m] = top_size;
    end
  endtask

  task automatic largest_clique(output logic [SIZE_W-1:0] size);
    int unsigned n, lw, hw, total, best;
    logic [63:0] all, common;
    n = vcount;
    if (n > NUM_VERT) n = NUM_VERT;
    if (n > 2 * HALF) n = 2 * HALF;
    lw = n / 2;
    hw = n - lw;
    fill_table(1'b0, 0, lw);
    fill_table(1'b1, lw, hw);
    all  = (64'd1 << n) - 1;
    best = 0;
    for (int unsigned m = 0; m < (1 << lw); m++) begin
      common = all;
      for (int unsigned j = 0; j < lw; j++)
        if (m[j]) common &= {32'd0, adj[j]};
      common >>= lw;
      total = low_best[m] + high_best[common[HALF-1:0]];
      if (total > best) best = total;
    end
    size = SIZE_W'(best);
  endtask

  always @(posedge clk) begin
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] due;
    if (rst) begin
      vcount     <= 6'd32;
      fail_count <= 0;
      pending    <= 0;
      for (int i = 0; i < NUM_VERT; i++) adj[i] = '0;
      sizes_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == 2'(REG_VERTEX_COUNT * 4))
        vcount <= pwdata[COUNT_W-1:0];
      if (rows.valid && rows.ready) begin
        // The stored row always carries the vertex's own bit.
        adj[rows.vertex_index] = rows.neighbour_row | (32'd1 << rows.vertex_index);
        if (rows.last_row) begin
          largest_clique(size);
          sizes_due.push_back(size);
        end
      end
      if (res.valid && res.ready) begin
        if (sizes_due.size() == 0) begin
          $error("unexpected result word: clique_size actual %0d", res.clique_size);
          fail_count <= fail_count + 1;
        end else begin
          due = sizes_due.pop_front();
          if (due !== res.clique_size) begin
            $error("clique_size mismatch: expected %0d actual %0d", due, res.clique_size);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= sizes_due.size();
    end
  end

endmodule : mcmm_checker

// ===== sim/tb_max_clique_meet_in_middle.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_max_clique_meet_in_middle
// Drives random graphs with planted cliques through the clique search.
// Rows go in with random gaps, results are taken with random stalls, and the
// vertex count is changed between searches, including zero and beyond range.
// ----------------------------------------------------------------------------
module tb_max_clique_meet_in_middle;
  import mcmm_pkg::*;

  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam int     ROW_TARGET  = 1050;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  longint      cycles = 0;
  int          rows_sent, searches;
  bit          held_once;
  bit          hold_req = 1'b0;

  mcmm_row_if rows ();
  mcmm_res_if res ();

  max_clique_meet_in_middle u_top (
    .clk, .rst, .rows_in(rows), .result_out(res),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mcmm_checker u_chk (
    .clk, .rst, .rows, .res, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_max_clique_meet_in_middle: errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_word(logic [4:0] idx, logic [31:0] nrow, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rows.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rows.valid         <= 1'b1;
    rows.vertex_index  <= idx;
    rows.neighbour_row <= nrow;
    rows.last_row      <= last;
    do @(posedge clk); while (!rows.ready);
    rows_sent++;
    if (last) searches++;
  endtask

  // Waits for every result, then lets the block settle before a register write.
  task automatic set_count(logic [5:0] n);
    @(posedge clk);
    rows.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 2'(REG_VERTEX_COUNT * 4);
    pwdata  <= {2'($urandom_range(0, 3)), 24'd0, n};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One graph: a planted clique over random background edges.
  task automatic send_graph(int n);
    logic [31:0] clique, vmask, nrow;
    int          count;
    logic [4:0]  idx;
    vmask  = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 1);
    clique = $urandom & $urandom & vmask;
    if ($urandom_range(0, 3) == 0) clique = $urandom & vmask;
    count = $urandom_range(n, n + 6);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0 || n == 0) idx = 5'($urandom);
      else idx = 5'(i % n);
      case ($urandom_range(0, 3))
        0: nrow = $urandom;
        1: nrow = $urandom & $urandom & $urandom;
        default: nrow = $urandom & $urandom;
      endcase
      if (clique[idx]) nrow |= clique;
      send_word(idx, nrow, i == count - 1);
    end
  endtask

  initial begin
    int n, r;
    rst            = 1'b1;
    rows.valid    <= 1'b0;
    rows.vertex_index  <= '0;
    rows.neighbour_row <= '0;
    rows.last_row <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rows_sent = 0;
    searches  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty graph, single vertex, extreme rows, out-of-range count.
    set_count(6'd0);
    send_word(5'd0, 32'hFFFF_FFFF, 1'b1);
    set_count(6'd1);
    send_word(5'd0, 32'h0000_0000, 1'b1);
    set_count(6'd2);
    send_word(5'd1, 32'h0000_0000, 1'b0);
    send_word(5'd0, 32'h0000_0000, 1'b1);
    send_word(5'd1, 32'hFFFF_FFFF, 1'b1);
    set_count(6'd5);
    for (int i = 0; i < 5; i++) send_word(5'(i), 32'hFFFF_FFFF, 1'b0);
    send_word(5'd31, 32'hFFFF_FFFF, 1'b1);
    send_word(5'd2, 32'h0000_0000, 1'b1);
    set_count(6'd3);
    send_word(5'd0, 32'hFFFF_FFF8, 1'b1);
    // Largest count: clamps to the full 32-vertex search.
    set_count(6'd63);
    for (int i = 0; i < 32; i++) send_word(5'(i), 32'hFFFF_FFFF, i == 31);

    // Back-to-back graphs under a long result hold-off, so that a finished
    // search waits behind the held result and the row side stalls.
    set_count(6'd4);
    hold_req = 1'b1;
    send_graph(4);
    send_graph(4);
    send_graph(4);

    while (rows_sent < ROW_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 78) n = $urandom_range(1, 12);
      else if (r < 94) n = $urandom_range(13, 18);
      else if (r < 97) n = $urandom_range(19, 22);
      else n = $urandom_range(0, 1);
      set_count(6'(n));
      send_graph(n);
      // Rows persist: sometimes rerun with one row overwritten.
      if ($urandom_range(0, 4) == 0 && n > 0)
        send_word(5'($urandom_range(0, n - 1)), $urandom, 1'b1);
    end

    @(posedge clk);
    rows.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d row words covering %0d searches, vertex counts 0 to 63.",
             rows_sent, searches);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_max_clique_meet_in_middle: clean");
    end else begin
      $display("tb_max_clique_meet_in_middle: errors");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off while rows keep coming.
  initial begin
    int r, hold;
    res.ready <= 1'b0;
    held_once = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held_once && hold_req && res.valid) begin
        held_once = 1'b1;
        res.ready <= 1'b0;
        hold = 0;
        while (hold < 2000) begin
          @(posedge clk);
          hold++;
        end
        res.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) res.ready <= 1'b1;
        else if (r < 95) res.ready <= 1'b0;
        else begin
          res.ready <= 1'b0;
          repeat ($urandom_range(5, 60)) @(posedge clk);
          res.ready <= 1'b1;
        end
      end
    end
  end

endmodule : tb_max_clique_meet_in_middle

// ===== files.f =====
hdl/mcmm_pkg.sv
hdl/mcmm_if.sv
hdl/mcmm_table.sv
hdl/max_clique_meet_in_middle.sv
sim/mcmm_checker.sv
sim/tb_max_clique_meet_in_middle.sv
